[hw/rtl/alli_pkg.sv]
// types and constants shared by the array linked list block
// no dependencies; imported by alli_engine, the top level and the checker
`default_nettype none

package alli_pkg;

    localparam int unsigned POS_W        = 11;
    localparam int unsigned SLOT_FIELD_W = 10;
    localparam int unsigned VAL_W        = 32;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_PAST_END = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_LINK,
        S_VAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  member_number;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic signed [VAL_W-1:0]  value;
        logic                     appended_at_end;
    } t_out_word;

endpackage

`default_nettype wire

[hw/rtl/alli_engine.sv]
// list engine: link and value memories, head pointer, slot counter and walk sequencer
// depends on alli_pkg
`default_nettype none

module alli_engine #(
    parameter int unsigned SLOTS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  alli_pkg::t_in_word   i_req,
    input  wire                  i_res_ready,
    output logic                 o_busy,
    output logic                 o_done,
    output alli_pkg::t_out_word  o_res
);
    import alli_pkg::*;

    localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned LW  = SW + 1;
    localparam int unsigned CW  = SW + 1;
    localparam int unsigned SLW = (SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W;

    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SW-1:0] s);
        logic [SLW-1:0] e;
        e = SLW'(s);
        return e[SLOT_FIELD_W-1:0];
    endfunction

    // link entry: msb set marks end of list
    logic [LW-1:0]    link_mem [SLOTS];
    logic [VAL_W-1:0] val_mem  [SLOTS];

    t_state           r_state, n_state;
    t_in_word         r_req, n_req;
    logic [LW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_used, n_used;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [SW-1:0]    r_fresh, n_fresh;
    logic [POS_W-1:0] r_left, n_left;
    t_out_word        r_res, n_res;

    logic [LW-1:0]    r_link_rd;
    logic [VAL_W-1:0] r_val_rd;

    logic             link_we;
    logic [SW-1:0]    link_waddr;
    logic [LW-1:0]    link_wdata;
    logic [SW-1:0]    link_raddr;
    logic             val_we;
    logic [SW-1:0]    val_waddr;
    logic [SW-1:0]    val_raddr;

    logic             full;
    logic             head_null;
    logic [SW-1:0]    head_slot;
    logic [SW-1:0]    fresh;
    logic             nx_null;
    logic [SW-1:0]    nx_slot;

    assign full      = (r_used == CW'(SLOTS));
    assign head_null = r_head[SW];
    assign head_slot = r_head[SW-1:0];
    assign fresh     = r_used[SW-1:0];
    assign nx_null   = r_link_rd[SW];
    assign nx_slot   = r_link_rd[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        r_link_rd <= link_mem[link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[val_waddr] <= r_req.member_number;
        end
        r_val_rd <= val_mem[val_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '1;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_ptr   <= n_ptr;
        r_fresh <= n_fresh;
        r_left  <= n_left;
        r_res   <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_head     = r_head;
        n_used     = r_used;
        n_ptr      = r_ptr;
        n_fresh    = r_fresh;
        n_left     = r_left;
        n_res      = r_res;
        link_we    = 1'b0;
        link_waddr = r_fresh;
        link_wdata = r_link_rd;
        link_raddr = r_ptr;
        val_we     = 1'b0;
        val_waddr  = fresh;
        val_raddr  = r_ptr;
        o_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res = '{status: ST_OK, slot: '0, value: '0, appended_at_end: 1'b0};
                unique case (r_req.func)
                    FUNC_INSERT: begin
                        if (full) begin
                            n_res.status = ST_FULL;
                            n_state      = S_EMIT;
                        end else begin
                            val_we     = 1'b1;
                            n_used     = r_used + CW'(1);
                            n_fresh    = fresh;
                            n_res.slot = slot_field(fresh);
                            if (head_null || r_req.position == '0) begin
                                // front insert
                                link_we    = 1'b1;
                                link_waddr = fresh;
                                link_wdata = r_head;
                                n_head     = {1'b0, fresh};
                                n_state    = S_EMIT;
                            end else begin
                                link_raddr = head_slot;
                                n_ptr      = head_slot;
                                n_left     = r_req.position - POS_W'(1);
                                n_state    = S_WALK;
                            end
                        end
                    end
                    FUNC_READ: begin
                        if (head_null) begin
                            n_res.status = ST_PAST_END;
                            n_state      = S_EMIT;
                        end else if (r_req.position == '0) begin
                            n_ptr     = head_slot;
                            val_raddr = head_slot;
                            n_state   = S_VAL;
                        end else begin
                            n_ptr      = head_slot;
                            link_raddr = head_slot;
                            n_left     = r_req.position;
                            n_state    = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                unique case (r_req.func)
                    FUNC_INSERT: begin
                        if (r_left == '0 || nx_null) begin
                            // new node takes over the successor of the current node
                            link_we                = 1'b1;
                            link_waddr             = r_fresh;
                            link_wdata             = r_link_rd;
                            n_res.appended_at_end  = (r_left != '0);
                            n_state                = S_LINK;
                        end else begin
                            n_ptr      = nx_slot;
                            link_raddr = nx_slot;
                            n_left     = r_left - POS_W'(1);
                        end
                    end
                    FUNC_READ: begin
                        if (nx_null) begin
                            n_res.status = ST_PAST_END;
                            n_state      = S_EMIT;
                        end else begin
                            n_ptr  = nx_slot;
                            n_left = r_left - POS_W'(1);
                            if (r_left == POS_W'(1)) begin
                                val_raddr = nx_slot;
                                n_state   = S_VAL;
                            end else begin
                                link_raddr = nx_slot;
                            end
                        end
                    end
                endcase
            end
            S_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_ptr;
                link_wdata = {1'b0, r_fresh};
                n_state    = S_EMIT;
            end
            S_VAL: begin
                n_res.slot  = slot_field(r_ptr);
                n_res.value = r_val_rd;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

[hw/rtl/array_linked_list_positional_insert.sv]
// top level of the array linked list: input handshake and output register
// depends on alli_pkg and alli_engine
//
// Usage:
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
// operation: insert at a position or read the entry at a position.
// Output channel (o_out_valid / i_out_ready / o_out_word) returns exactly
// one word per accepted input word, in order.
// One word is processed at a time. Each walk step is one read of the link
// memory, one per cycle. Front inserts, refused inserts and reads of an
// empty list need no walk; an insert at position p walks from the head and
// stops at the tail, and a read at index p walks from the head and stops
// at the end of the list. o_in_ready rises together with o_out_valid, so
// the next word can be taken as soon as the result appears.
// The output register holds a result while the receiver stalls; the block
// may take the next word meanwhile and waits before loading its result.
// Reset (synchronous, active low) empties the list and the slot counter;
// memory contents are left as they are.
`default_nettype none

module array_linked_list_positional_insert #(
    parameter int unsigned SLOTS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  alli_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output alli_pkg::t_out_word  o_out_word
);
    import alli_pkg::*;

    logic      busy;
    logic      done;
    logic      res_ready;
    t_out_word res;
    logic      r_out_valid;
    t_out_word r_out_word;

    assign o_in_ready = !busy;
    assign res_ready  = !r_out_valid || i_out_ready;

    alli_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_req       (i_in_word),
        .i_res_ready (res_ready),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[hw/rtl/alli_checker.sv]
// port-level checks for the array linked list, bound to the top level
// depends on alli_pkg and array_linked_list_positional_insert
`default_nettype none

module alli_port_checks (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input alli_pkg::t_out_word o_out_word
);
    import alli_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready after accepting a word");

    // a new result only appears at the end of an operation
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an operation in flight");

    // refused inserts and reads past the end carry zero fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |->
            o_out_word.slot == '0 && o_out_word.value == '0
            && !o_out_word.appended_at_end)
        else $error("error result with nonzero fields");

endmodule

bind array_linked_list_positional_insert alli_port_checks u_alli_port_checks (.*);

`default_nettype wire

[sim/alli_checker.sv]
// checker for the array linked list: watches both channels, keeps its own list
// and compares each output word with the oldest predicted one; uses alli_pkg
`timescale 1ns / 100ps

module alli_checker
    import alli_pkg::*;
#(
    parameter int unsigned SLOTS = 1024
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  t_in_word   i_in_word,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  t_out_word  i_out_word,
    output int         o_mismatches,
    output int         o_pending
);

    localparam logic [POS_W-1:0] NIL = '1;

    logic [POS_W-1:0]        next_slot [0:SLOTS-1];
    logic signed [VAL_W-1:0] member_at [0:SLOTS-1];
    logic [POS_W-1:0]        head_slot;
    logic [POS_W-1:0]        slots_taken;
    t_out_word               expected_words [$];
    int                      mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic t_out_word predict_list_op(input t_in_word w);
        t_out_word        r;
        logic [POS_W-1:0] fresh;
        logic [POS_W-1:0] ptr;
        logic [POS_W-1:0] nx;
        int               i;
        r = '0;
        r.status = ST_OK;
        if (w.func == FUNC_INSERT) begin
            if (slots_taken >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                fresh = slots_taken;
                slots_taken = slots_taken + 1'b1;
                member_at[fresh[SLOT_FIELD_W-1:0]] = w.member_number;
                if (head_slot == NIL || w.position == '0) begin
                    next_slot[fresh[SLOT_FIELD_W-1:0]] = head_slot;
                    head_slot = fresh;
                end else begin
                    ptr = head_slot;
                    for (i = 1; i < w.position; i++) begin
                        nx = next_slot[ptr[SLOT_FIELD_W-1:0]];
                        if (nx >= SLOTS) begin
                            r.appended_at_end = 1'b1;
                            break;
                        end
                        ptr = nx;
                    end
                    next_slot[fresh[SLOT_FIELD_W-1:0]] = next_slot[ptr[SLOT_FIELD_W-1:0]];
                    next_slot[ptr[SLOT_FIELD_W-1:0]] = fresh;
                end
                r.slot = fresh[SLOT_FIELD_W-1:0];
            end
        end else begin
            ptr = head_slot;
            for (i = 0; i < w.position && ptr < SLOTS; i++)
                ptr = next_slot[ptr[SLOT_FIELD_W-1:0]];
            if (ptr >= SLOTS) begin
                r.status = ST_PAST_END;
            end else begin
                r.slot  = ptr[SLOT_FIELD_W-1:0];
                r.value = member_at[ptr[SLOT_FIELD_W-1:0]];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            head_slot   = NIL;
            slots_taken = '0;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns unexpected output word %h", $time, i_out_word);
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_word.status));
                    check_field("slot", 32'(want.slot), 32'(i_out_word.slot));
                    check_field("value", want.value, i_out_word.value);
                    check_field("appended_at_end", 32'(want.appended_at_end),
                                32'(i_out_word.appended_at_end));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(predict_list_op(i_in_word));
        end
        o_pending    <= expected_words.size();
        o_mismatches <= mismatch_count;
    end

endmodule

[sim/tb.sv]
// testbench top for array_linked_list_positional_insert: clock, reset, stimulus
// and verdict; depends on alli_pkg, the block and alli_checker
`timescale 1ns / 100ps

module tb;
    import alli_pkg::*;

    localparam int unsigned SLOTS       = 1024;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned PHASE_WORDS = 138;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_in_word    in_word   = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_word   out_word;
    int          mismatches;
    int          pending;
    int unsigned cycles          = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;
    int unsigned list_len        = 0;

    array_linked_list_positional_insert #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    alli_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input t_func f, input int unsigned pos, input logic [31:0] v);
        t_in_word w;
        w.func          = f;
        w.position      = pos[POS_W-1:0];
        w.member_number = v;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (f == FUNC_INSERT && list_len < SLOTS)
            list_len++;
    endtask

    task automatic send_random_word();
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(99);
        if (pick < 55)
            pos = $urandom_range(4);
        else if (pick < 85)
            pos = $urandom_range(list_len + 1);
        else
            pos = $urandom_range(2047);
        if ($urandom_range(99) < 60)
            send_word(FUNC_INSERT, pos, $urandom);
        else
            send_word(FUNC_READ, pos, $urandom);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, then front, middle and tail inserts
        send_word(FUNC_READ, 0, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 5, 32'h7FFF_FFFF);
        send_word(FUNC_INSERT, 0, 32'h8000_0000);
        send_word(FUNC_INSERT, 1, 32'h0000_0001);
        send_word(FUNC_INSERT, 2047, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 3, 32'h0000_0000);
        send_word(FUNC_INSERT, 1024, 32'h5555_5555);
        send_word(FUNC_INSERT, 1023, 32'hAAAA_AAAA);
        send_word(FUNC_INSERT, 2, 32'h1234_5678);
        for (int i = 0; i <= 8; i++)
            send_word(FUNC_READ, i, $urandom);
        send_word(FUNC_READ, 1024, 32'h0);
        send_word(FUNC_READ, 2047, 32'h0);
        send_word(FUNC_READ, 1023, 32'h0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct <= 0;
                    stall_pct       <= 0;
                end
                1: begin
                    sender_idle_pct <= 53;
                    stall_pct       <= 0;
                end
                2: begin
                    sender_idle_pct <= 0;
                    stall_pct       <= 53;
                end
                default: begin
                    sender_idle_pct <= 21;
                    stall_pct       <= 21;
                end
            endcase
            repeat (PHASE_WORDS) send_random_word();
        end

        // front, tail and middle inserts, then reads over the final list
        sender_idle_pct <= 21;
        stall_pct       <= 21;
        send_word(FUNC_INSERT, 0, $urandom);
        send_word(FUNC_INSERT, 2047, $urandom);
        send_word(FUNC_INSERT, 1, $urandom);
        send_word(FUNC_READ, 1023, $urandom);
        send_word(FUNC_READ, 1024, $urandom);
        send_word(FUNC_READ, 2047, $urandom);
        send_word(FUNC_READ, 0, $urandom);
        send_word(FUNC_READ, $urandom_range(1023), $urandom);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
